// ===== src/ps2mpc_pkg.sv =====
package ps2mpc_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MOTION_GAIN   = 2'd2;

    // Status byte bit positions
    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    localparam logic [12:0] MAX_SCREEN = 13'd4096;

    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd320;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd200;
    localparam logic [3:0]  RST_MOTION_GAIN   = 4'd3;
    localparam logic [11:0] RST_POS_X         = 12'd160;
    localparam logic [11:0] RST_POS_Y         = 12'd100;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } t_phase;

    typedef struct packed {
        logic [11:0] cursor_x;
        logic [11:0] cursor_y;
        logic [2:0]  button_bits;
        logic        overflow_dropped;
    } t_result;

    // Clamp a signed coordinate into [0, limit-1], where a zero size counts
    // as one and anything above the maximum counts as the maximum.
    function automatic logic [11:0] clamp_pos(input logic signed [14:0] v,
                                              input logic [12:0] size);
        logic [12:0] lim;
        logic [12:0] lim_m1;
        logic [11:0] res;
        if (size == 13'd0) begin
            lim = 13'd1;
        end else if (size > MAX_SCREEN) begin
            lim = MAX_SCREEN;
        end else begin
            lim = size;
        end
        lim_m1 = lim - 13'd1;
        if (v < 15'sd0) begin
            res = 12'd0;
        end else if (v[13:0] >= {1'b0, lim}) begin
            res = lim_m1[11:0];
        end else begin
            res = v[11:0];
        end
        return res;
    endfunction

endpackage

// ===== src/ps2_mouse_packet_cursor_unit.sv =====
// PS/2 mouse packet decoder with a clamped cursor. Feed one received mouse
// byte per item; a byte with bit 3 set starts a packet, and the next two bytes
// are the X and Y movement bytes. After the third byte the unit delivers one
// result item with the new cursor position, the three button bits and an
// overflow flag; the first two bytes of a packet and stray bytes deliver
// nothing. Motion is gain times the delta (Y grows downward), clamped to the
// configured screen, and skipped when an overflow bit is set. Throughput is
// one byte per cycle while the result register is free or being emptied:
// each byte is held in the input register, and the decode, multiply by the
// 4-bit gain, add and clamp run in the single step from that register into
// the result register. The last byte of a packet is loaded into the input
// register on accept, and its result into the result register when that
// byte steps on. Write configuration only while no bytes are in flight.
module ps2_mouse_packet_cursor_unit
    import ps2mpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_cursor_x,
    output logic [11:0] o_cursor_y,
    output logic [2:0]  o_button_bits,
    output logic        o_overflow_dropped
);

    // Configuration registers
    logic [12:0] r_screen_width;
    logic [12:0] r_screen_height;
    logic [3:0]  r_motion_gain;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Packet state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_xdelta, n_xdelta;
    logic [11:0] r_pos_x, n_pos_x;
    logic [11:0] r_pos_y, n_pos_y;

    // Result register
    logic        r_out_valid;
    t_result     r_result, n_result;

    logic        has_result;
    logic        step;

    logic signed [14:0] dx;
    logic signed [14:0] dy;
    logic signed [14:0] gain_s;
    logic signed [14:0] move_x;
    logic signed [14:0] move_y;
    logic               ovf;

    // A byte in the input register moves on when it yields nothing, or when
    // the result register is free or being emptied this cycle.
    assign has_result = (r_phase == PH_YDELTA);
    assign step       = r_in_valid && (!has_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // Sign-extend the deltas from the status sign bits and scale by the gain
    assign dx     = {{7{r_status[X_SIGN_BIT]}}, r_xdelta};
    assign dy     = {{7{r_status[Y_SIGN_BIT]}}, r_in_byte};
    assign gain_s = {11'd0, r_motion_gain};
    assign move_x = $signed({3'd0, r_pos_x}) + gain_s * dx;
    assign move_y = $signed({3'd0, r_pos_y}) - gain_s * dy;
    assign ovf    = r_status[X_OVF_BIT] | r_status[Y_OVF_BIT];

    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_xdelta = r_xdelta;
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_result = r_result;
        unique case (r_phase)
            PH_XDELTA: begin
                n_xdelta = r_in_byte;
                n_phase  = PH_YDELTA;
            end
            PH_YDELTA: begin
                n_phase = PH_STATUS;
                if (!ovf) begin
                    n_pos_x = clamp_pos(move_x, r_screen_width);
                    n_pos_y = clamp_pos(move_y, r_screen_height);
                end
                n_result.cursor_x         = n_pos_x;
                n_result.cursor_y         = n_pos_y;
                n_result.button_bits      = r_status[2:0];
                n_result.overflow_dropped = ovf;
            end
            default: begin
                // Hunt for a status byte; drop anything without the sync bit
                if (r_in_byte[SYNC_BIT]) begin
                    n_status = r_in_byte;
                    n_phase  = PH_XDELTA;
                end else begin
                    n_phase = PH_STATUS;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_motion_gain   <= RST_MOTION_GAIN;
            r_in_valid      <= 1'b0;
            r_phase         <= PH_STATUS;
            r_status        <= 8'd0;
            r_xdelta        <= 8'd0;
            r_pos_x         <= RST_POS_X;
            r_pos_y         <= RST_POS_Y;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                    REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                    REG_MOTION_GAIN:   r_motion_gain   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            // Input register: load on accept, empty when the byte moves on
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end

            if (step) begin
                r_phase  <= n_phase;
                r_status <= n_status;
                r_xdelta <= n_xdelta;
                r_pos_x  <= n_pos_x;
                r_pos_y  <= n_pos_y;
            end

            // Result register: hold until taken
            if (step && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (step && has_result) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_cursor_x         = r_result.cursor_x;
    assign o_cursor_y         = r_result.cursor_y;
    assign o_button_bits      = r_result.button_bits;
    assign o_overflow_dropped = r_result.overflow_dropped;

endmodule

// ===== tb/sv/ps2_mouse_packet_cursor_unit_tb.sv =====
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_unit_tb;
    import ps2mpc_pkg::*;

    // Cycles with no item moving on either side before the run is called hung.
    // The slowest correct stretch is a configuration pause: drain, the settle
    // cycles and the write itself, plus a sender gap and receiver stalls.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_BYTES    = 200;

    // Holds the expected cursor results: decodes every accepted mouse byte
    // the same way the unit must and queues one result per full packet.
    class cursor_scoreboard;
        logic [12:0] scr_width;
        logic [12:0] scr_height;
        logic [3:0]  gain;
        t_phase      phase;
        logic [7:0]  status;
        logic [7:0]  x_byte;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        t_result     expected_q[$];
        int          mismatches;

        function new();
            scr_width  = RST_SCREEN_WIDTH;
            scr_height = RST_SCREEN_HEIGHT;
            gain       = RST_MOTION_GAIN;
            phase      = PH_STATUS;
            status     = 8'h00;
            x_byte     = 8'h00;
            pos_x      = RST_POS_X;
            pos_y      = RST_POS_Y;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] data);
            case (idx)
                REG_SCREEN_WIDTH:  scr_width  = data;
                REG_SCREEN_HEIGHT: scr_height = data;
                REG_MOTION_GAIN:   gain       = data[3:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] fit_to_screen(int v, logic [12:0] size);
            int lim;
            lim = (size == 13'd0) ? 1 : ((size > MAX_SCREEN) ? int'(MAX_SCREEN) : int'(size));
            if (v < 0) return 12'd0;
            if (v >= lim) return 12'(lim - 1);
            return 12'(v);
        endfunction

        function void note_byte(logic [7:0] b);
            int      dx;
            int      dy;
            t_result r;
            case (phase)
                PH_XDELTA: begin
                    x_byte = b;
                    phase  = PH_YDELTA;
                end
                PH_YDELTA: begin
                    phase = PH_STATUS;
                    dx = status[X_SIGN_BIT] ? int'(x_byte) - 256 : int'(x_byte);
                    dy = status[Y_SIGN_BIT] ? int'(b) - 256 : int'(b);
                    r.overflow_dropped = status[X_OVF_BIT] | status[Y_OVF_BIT];
                    if (!r.overflow_dropped) begin
                        pos_x = fit_to_screen(int'(pos_x) + int'(gain) * dx, scr_width);
                        pos_y = fit_to_screen(int'(pos_y) - int'(gain) * dy, scr_height);
                    end
                    r.cursor_x    = pos_x;
                    r.cursor_y    = pos_y;
                    r.button_bits = status[2:0];
                    expected_q.push_back(r);
                end
                default: begin
                    if (b[SYNC_BIT]) begin
                        status = b;
                        phase  = PH_XDELTA;
                    end else begin
                        phase  = PH_STATUS;
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d",
                                          got.cursor_x, got.cursor_y));
                return;
            end
            want = expected_q.pop_front();
            if (got.cursor_x != want.cursor_x)
                report_mismatch($sformatf("cursor_x got %0d want %0d",
                                          got.cursor_x, want.cursor_x));
            if (got.cursor_y != want.cursor_y)
                report_mismatch($sformatf("cursor_y got %0d want %0d",
                                          got.cursor_y, want.cursor_y));
            if (got.button_bits != want.button_bits)
                report_mismatch($sformatf("button_bits got %0d want %0d",
                                          got.button_bits, want.button_bits));
            if (got.overflow_dropped != want.overflow_dropped)
                report_mismatch($sformatf("overflow_dropped got %0d want %0d",
                                          got.overflow_dropped, want.overflow_dropped));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_SCREEN_WIDTH;
    logic [12:0] i_cfg_data = 13'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [11:0] o_cursor_x;
    logic [11:0] o_cursor_y;
    logic [2:0]  o_button_bits;
    logic        o_overflow_dropped;

    // Set during the no-idle stretch: both sides run flat out.
    logic steady = 1'b0;
    int   bytes_sent = 0;
    int   quiet_cycles = 0;

    cursor_scoreboard sb = new();

    ps2_mouse_packet_cursor_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_rx_byte          (i_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_cursor_x         (o_cursor_x),
        .o_cursor_y         (o_cursor_y),
        .o_button_bits      (o_button_bits),
        .o_overflow_dropped (o_overflow_dropped)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the result side about a third of the time, never while steady.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 36);
    end

    // Check every result item taken by the receiver against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.cursor_x         = o_cursor_x;
            got.cursor_y         = o_cursor_y;
            got.button_bits      = o_button_bits;
            got.overflow_dropped = o_overflow_dropped;
            sb.check_result(got);
        end
    end

    // Count cycles in which no item moves; give up once the limit is hit.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ps2_mouse_packet_cursor_unit regression: fail");
            $finish;
        end
    end

    // Offer one byte; optionally idle first. Returns at the edge that accepts it,
    // with valid still high so the next byte can follow back to back.
    task push_byte(logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task push_packet(logic [7:0] st, logic [7:0] dx, logic [7:0] dy);
        push_byte(st);
        push_byte(dx);
        push_byte(dy);
    endtask

    // Drop valid and hold the sender until every expected result has come back.
    task hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Write one register with the unit idle: drain, let stray bytes that make
    // no result clear the pipeline, then pulse the write enable.
    task write_reg(logic [1:0] idx, logic [12:0] data);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    function logic [12:0] pick_screen_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 13'd0;
        if (r == 1) return 13'($urandom_range(4097, 8191));
        if (r == 2) return MAX_SCREEN;
        if (r < 9) return 13'($urandom_range(1, 64));
        return 13'($urandom_range(65, 4096));
    endfunction

    initial begin
        int         r;
        int         hold_at;
        int         phase_start;
        logic [7:0] st;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset configuration: stray bytes without the sync bit
        // are dropped, then drive the cursor into both corners.
        push_byte(8'h00);
        push_byte(8'hF7);
        push_packet(8'h08, 8'h7F, 8'h80);   // full positive swing, clamp right and top
        push_packet(8'h3F, 8'h80, 8'h00);   // both signs, all buttons, clamp left and bottom
        push_packet(8'h48, 8'hFF, 8'hFF);   // X overflow: motion dropped
        push_packet(8'h8D, 8'h01, 8'h01);   // Y overflow with buttons

        // Zero width collapses X to column 0; zero gain leaves Y alone.
        write_reg(REG_SCREEN_WIDTH, 13'd0);
        write_reg(REG_SCREEN_HEIGHT, 13'd8191);
        write_reg(REG_MOTION_GAIN, 13'd0);
        push_packet(8'h0A, 8'h40, 8'hC0);

        // Largest gain, largest screen, one-row screen.
        write_reg(REG_MOTION_GAIN, 13'd15);
        write_reg(REG_SCREEN_WIDTH, MAX_SCREEN);
        write_reg(REG_SCREEN_HEIGHT, 13'd1);
        push_packet(8'h08, 8'hFF, 8'h7F);
        write_reg(REG_SCREEN_WIDTH, 13'd8191);
        push_packet(8'h08, 8'hFF, 8'h00);   // oversized width acts as the maximum

        // Shrink the screen: an overflow packet still reports the old column,
        // the next clean packet pulls it inside.
        write_reg(REG_SCREEN_WIDTH, 13'd100);
        push_packet(8'hC9, 8'h10, 8'h10);
        push_packet(8'h09, 8'h00, 8'h00);

        // Random part: mostly well-formed packets with random content, some
        // stray bytes that shift the framing, a fresh configuration per phase.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph == 0) begin
                write_reg(REG_SCREEN_WIDTH, RST_SCREEN_WIDTH);
                write_reg(REG_SCREEN_HEIGHT, RST_SCREEN_HEIGHT);
                write_reg(REG_MOTION_GAIN, {9'd0, RST_MOTION_GAIN});
            end else begin
                write_reg(REG_SCREEN_WIDTH, pick_screen_size());
                write_reg(REG_SCREEN_HEIGHT, pick_screen_size());
                write_reg(REG_MOTION_GAIN, 13'($urandom_range(0, 15)));
            end
            steady <= (ph == 2);
            phase_start = bytes_sent;
            hold_at = phase_start + $urandom_range(20, PHASE_BYTES - 20);
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    push_byte(8'($urandom));
                end else begin
                    st = 8'($urandom) | 8'h08;
                    if ($urandom_range(0, 99) < 80) st[7:6] = 2'b00;
                    push_packet(st, 8'($urandom), 8'($urandom));
                end
                if (bytes_sent >= hold_at && bytes_sent - 3 < hold_at) begin
                    hold_until_drained();
                end
            end
        end

        // Drain: wait for every outstanding result, then keep the clock running so a
        // spurious extra result would still be caught.
        steady <= 1'b0;
        hold_until_drained();
        repeat (8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ps2_mouse_packet_cursor_unit regression: pass");
        end else begin
            $display("ps2_mouse_packet_cursor_unit regression: fail");
        end
        $finish;
    end

endmodule
